// ----- rtl/jet_pkg.sv -----
package jet_pkg;

	localparam int WORD_W        = 32;
	localparam int COEF_W        = 31;
	localparam int CAP_W         = 10;
	localparam int RESULT_W      = 10;
	localparam int PROD_W        = 64;
	localparam int ADDR_W        = 2;
	localparam int FRAC_BITS_DEF = 28;
	localparam int COUNT_BITS_DEF = 10;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic signed [COEF_W-1:0] JULIA_REAL_RST = -31'sd174613680;
	localparam logic signed [COEF_W-1:0] JULIA_IMAG_RST = -31'sd128372540;
	localparam logic [CAP_W-1:0]         MAX_ITER_RST   = 10'd255;
	localparam logic                     POWER_MODE_RST = 1'b0;

	typedef enum logic [ADDR_W-1:0] {
		REG_JULIA_REAL = 2'd0,
		REG_JULIA_IMAG = 2'd1,
		REG_MAX_ITER   = 2'd2,
		REG_POWER_MODE = 2'd3
	} reg_index_t;

	typedef enum logic {
		CLS_ITERATE = 1'b0,
		CLS_EXIT    = 1'b1
	} item_class_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		item_class_t              cls;
	} item_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] c_real;
		logic signed [COEF_W-1:0] c_imag;
		logic [CAP_W-1:0]         max_iter;
		logic                     quartic;
	} cfg_t;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W:0] v);
		logic signed [PROD_W:0] hi;
		logic signed [PROD_W:0] lo;
		hi = (PROD_W+1)'({1'b0, {(WORD_W-1){1'b1}}});
		lo = -hi - (PROD_W+1)'(1);
		if (v > hi) begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end
		return v[WORD_W-1:0];
	endfunction

endpackage

// ----- rtl/jet_front.sv -----
module jet_front import jet_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [WORD_W-1:0] point_real,
	input  logic signed [WORD_W-1:0] point_imag,
	input  logic [CAP_W-1:0]         max_iter,
	output logic                     q_push,
	output item_t                    q_item,
	input  logic                     q_full
);

	localparam logic signed [PROD_W-1:0] RADIUS = PROD_W'(64'sd1 <<< (FRAC_BITS + 1));

	logic                     valid_s1;
	item_t                    item_s1;
	logic                     accept;
	logic                     outside;
	logic [COUNT_BITS-1:0]    cap_w;
	logic signed [PROD_W-1:0] x_w;
	logic signed [PROD_W-1:0] y_w;

	assign cap_w  = COUNT_BITS'(max_iter);
	assign x_w    = PROD_W'(point_real);
	assign y_w    = PROD_W'(point_imag);
	assign outside = (x_w > RADIUS) || (x_w < -RADIUS) || (y_w > RADIUS) || (y_w < -RADIUS);

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.x   <= point_real;
			item_s1.y   <= point_imag;
			item_s1.cls <= (outside || cap_w == '0) ? CLS_EXIT : CLS_ITERATE;
		end
	end

endmodule

// ----- rtl/jet_queue.sv -----
module jet_queue import jet_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ----- rtl/jet_back.sv -----
module jet_back import jet_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  item_t               q_item,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                res_empty,
	input  logic                res_pop,
	output logic [RESULT_W-1:0] res_count
);

	localparam int DISK_EXP = 2 * FRAC_BITS + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic signed [WORD_W-1:0] x_q;
	logic signed [WORD_W-1:0] y_q;
	logic [COUNT_BITS-1:0]    count_q;
	logic                     second_q;
	logic signed [PROD_W-1:0] xx_s1;
	logic signed [PROD_W-1:0] yy_s1;
	logic signed [PROD_W-1:0] xy_s1;
	logic                     res_valid_q;
	logic [RESULT_W-1:0]      res_q;

	logic signed [PROD_W-1:0] xx_w;
	logic signed [PROD_W-1:0] yy_w;
	logic signed [PROD_W-1:0] xy_w;
	logic signed [PROD_W-1:0] diff_w;
	logic signed [PROD_W-1:0] re_full;
	logic signed [PROD_W-1:0] im_full;
	logic signed [WORD_W-1:0] re_sat;
	logic signed [WORD_W-1:0] im_sat;
	logic signed [WORD_W:0]   re_sum;
	logic signed [WORD_W:0]   im_sum;
	logic signed [WORD_W-1:0] re_next;
	logic signed [WORD_W-1:0] im_next;
	logic [PROD_W:0]          mag_w;
	logic                     in_disk;
	logic [COUNT_BITS-1:0]    cap_w;
	logic                     res_free;
	logic                     res_load;

	assign cap_w = COUNT_BITS'(cfg.max_iter);

	assign xx_w = x_q * x_q;
	assign yy_w = y_q * y_q;
	assign xy_w = x_q * y_q;

	always_comb begin
		diff_w  = xx_s1 - yy_s1;
		re_full = diff_w >>> FRAC_BITS;
		im_full = xy_s1 >>> (FRAC_BITS - 1);
		re_sat  = sat_word((PROD_W+1)'(re_full));
		im_sat  = sat_word((PROD_W+1)'(im_full));
		re_sum  = (WORD_W+1)'(re_sat) + (WORD_W+1)'(cfg.c_real);
		im_sum  = (WORD_W+1)'(im_sat) + (WORD_W+1)'(cfg.c_imag);
		re_next = sat_word((PROD_W+1)'(re_sum));
		im_next = sat_word((PROD_W+1)'(im_sum));
		mag_w   = {1'b0, xx_s1} + {1'b0, yy_s1};
		in_disk = (DISK_EXP >= PROD_W) || (mag_w <= ((PROD_W+1)'(1) << DISK_EXP));
	end

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign res_free  = !res_valid_q || res_pop;
	assign res_load  = (state_q == ST_DONE) && res_free;
	assign res_empty = !res_valid_q;
	assign res_count = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			second_q    <= 1'b0;
			count_q     <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						x_q      <= q_item.x;
						y_q      <= q_item.y;
						count_q  <= '0;
						second_q <= 1'b0;
						state_q  <= (q_item.cls == CLS_EXIT) ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					xx_s1   <= xx_w;
					yy_s1   <= yy_w;
					xy_s1   <= xy_w;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (second_q) begin
						x_q      <= re_next;
						y_q      <= im_next;
						second_q <= 1'b0;
						state_q  <= ST_MUL;
					end else if (count_q >= cap_w || !in_disk) begin
						state_q <= ST_DONE;
					end else begin
						count_q <= count_q + COUNT_BITS'(1);
						if (cfg.quartic) begin
							x_q      <= re_sat;
							y_q      <= im_sat;
							second_q <= 1'b1;
						end else begin
							x_q <= re_next;
							y_q <= im_next;
						end
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						res_q   <= RESULT_W'(count_q);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/julia_escape_time_core.sv -----
// Julia set escape-time counter. Each pushed point z0 (signed fixed point with FRAC_BITS
// fraction bits) is iterated as z <- z^2 + c, or z^4 + c when power_mode is set, and the
// number of iterations done while |z| <= 2 is returned, capped at max_iterations. One
// shared set of three 32x32 multipliers, registered, serves each squaring; a quartic
// iteration uses it twice. A point runs in the engine until its count reaches the cap
// or |z| exceeds two. Points outside the square of half-width two, or any point with a
// zero cap, skip the multipliers. A two-entry queue and an input register ahead of the
// engine, and a result register after it, let the input and result sides stall on their
// own. The user must write configuration only while the block is idle; the block itself
// does not enforce this. A coefficient write beyond plus or minus two is dropped.
module julia_escape_time_core import jet_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [WORD_W-1:0] point_real,
	input  logic signed [WORD_W-1:0] point_imag,
	output logic                     empty,
	input  logic                     pop,
	output logic [RESULT_W-1:0]      escape_count,
	input  logic                     cfg_we,
	input  logic [ADDR_W-1:0]        cfg_addr,
	input  logic [COEF_W-1:0]        cfg_wdata
);

	localparam logic signed [PROD_W-1:0] COEF_LIMIT = PROD_W'(64'sd1 <<< (FRAC_BITS + 1));

	cfg_t                     cfg_q;
	logic signed [PROD_W-1:0] coef_w;
	logic                     coef_ok;
	logic                     q_push;
	item_t                    q_in;
	logic                     q_full;
	item_t                    q_out;
	logic                     q_empty;
	logic                     q_pop;

	assign coef_w  = PROD_W'($signed(cfg_wdata));
	assign coef_ok = (coef_w >= -COEF_LIMIT) && (coef_w <= COEF_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real   <= JULIA_REAL_RST;
			cfg_q.c_imag   <= JULIA_IMAG_RST;
			cfg_q.max_iter <= MAX_ITER_RST;
			cfg_q.quartic  <= POWER_MODE_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_addr))
				REG_JULIA_REAL: begin
					if (coef_ok) begin
						cfg_q.c_real <= $signed(cfg_wdata);
					end
				end
				REG_JULIA_IMAG: begin
					if (coef_ok) begin
						cfg_q.c_imag <= $signed(cfg_wdata);
					end
				end
				REG_MAX_ITER: begin
					cfg_q.max_iter <= cfg_wdata[CAP_W-1:0];
				end
				REG_POWER_MODE: begin
					cfg_q.quartic <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	jet_front #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.point_real (point_real),
		.point_imag (point_imag),
		.max_iter   (cfg_q.max_iter),
		.q_push     (q_push),
		.q_item     (q_in),
		.q_full     (q_full)
	);

	jet_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_in),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_item (q_out),
		.empty   (q_empty)
	);

	jet_back #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_item    (q_out),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.res_empty (empty),
		.res_pop   (pop),
		.res_count (escape_count)
	);

endmodule

// ----- dv/tb_julia_escape_time_core.sv -----
module tb_julia_escape_time_core import jet_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     ONE_Q      = 1 << FRAC_BITS_DEF;
	localparam int     TWO_Q      = 2 * ONE_Q;
	localparam longint COEF_LIMIT = longint'(1) << (FRAC_BITS_DEF + 1);
	localparam longint WORD_MAX   = 64'sd2147483647;
	localparam longint WORD_MIN   = -64'sd2147483648;
	localparam int     MAX_SHOWN  = 10;

	class escape_scoreboard;
		longint              c_real;
		longint              c_imag;
		int unsigned         cap;
		bit                  quartic;
		logic [RESULT_W-1:0] expected_counts[$];
		int                  errors;

		function new();
			c_real  = JULIA_REAL_RST;
			c_imag  = JULIA_IMAG_RST;
			cap     = MAX_ITER_RST;
			quartic = POWER_MODE_RST;
			errors  = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [COEF_W-1:0] data);
			longint coef;
			coef = longint'($signed(data));
			case (idx)
			REG_JULIA_REAL: begin
				if (coef >= -COEF_LIMIT && coef <= COEF_LIMIT) c_real = coef;
			end
			REG_JULIA_IMAG: begin
				if (coef >= -COEF_LIMIT && coef <= COEF_LIMIT) c_imag = coef;
			end
			REG_MAX_ITER: begin
				cap = data[CAP_W-1:0];
			end
			REG_POWER_MODE: begin
				quartic = data[0];
			end
			default: ;
			endcase
		endfunction

		function longint clamp_word(longint v);
			if (v > WORD_MAX) return WORD_MAX;
			if (v < WORD_MIN) return WORD_MIN;
			return v;
		endfunction

		function void square_once(input longint x, input longint y,
				output longint re, output longint im);
			re = clamp_word((x * x - y * y) >>> FRAC_BITS_DEF);
			im = clamp_word((x * y) >>> (FRAC_BITS_DEF - 1));
		endfunction

		function bit within_radius(longint x, longint y);
			longint unsigned ux;
			longint unsigned uy;
			ux = (x < 0) ? -x : x;
			uy = (y < 0) ? -y : y;
			return (ux * ux + uy * uy) <= (64'd1 << (2 * FRAC_BITS_DEF + 2));
		endfunction

		function logic [RESULT_W-1:0] escape_iterations(longint x0, longint y0);
			longint      x;
			longint      y;
			longint      re;
			longint      im;
			int unsigned count;
			x     = x0;
			y     = y0;
			count = 0;
			while (count < cap && within_radius(x, y)) begin
				square_once(x, y, re, im);
				if (quartic) square_once(re, im, re, im);
				x = clamp_word(re + c_real);
				y = clamp_word(im + c_imag);
				count++;
			end
			return count[RESULT_W-1:0];
		endfunction

		function void note_point(logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y);
			expected_counts.push_back(escape_iterations(x, y));
		endfunction

		function void check_count(logic [RESULT_W-1:0] got);
			logic [RESULT_W-1:0] want;
			if (expected_counts.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected escape_count %0d with no request pending", got);
			end else begin
				want = expected_counts.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("escape_count mismatch: expected %0d, got %0d", want, got);
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic signed [WORD_W-1:0] point_real;
	logic signed [WORD_W-1:0] point_imag;
	logic                     empty;
	logic                     pop;
	logic [RESULT_W-1:0]      escape_count;
	logic                     cfg_we;
	logic [ADDR_W-1:0]        cfg_addr;
	logic [COEF_W-1:0]        cfg_wdata;

	escape_scoreboard sb = new();
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;

	julia_escape_time_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.point_real   (point_real),
		.point_imag   (point_imag),
		.empty        (empty),
		.pop          (pop),
		.escape_count (escape_count),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_count(escape_count);
	end

	task automatic write_reg(reg_index_t idx, logic [COEF_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		sb.set_reg(idx, data);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_point(logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push       <= 1'b1;
		point_real <= x;
		point_imag <= y;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_point(x, y);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (sb.expected_counts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	function automatic logic signed [WORD_W-1:0] random_coord();
		case ($urandom_range(9))
		0, 1:    return $urandom();
		2:       return int'($urandom_range(32'h0800_0000)) + ONE_Q + ONE_Q / 2;
		default: return int'($urandom_range(32'h4000_0000)) - TWO_Q;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		return COEF_W'(int'($urandom_range(32'h4000_0000)) - TWO_Q);
	endfunction

	initial begin
		#(50_000_000);
		$display("[julia_escape_time_core] ERROR");
		$finish;
	end

	initial begin
		int unsigned n_items;
		int unsigned cap_val;
		arst_n     = 1'b0;
		push       = 1'b0;
		point_real = '0;
		point_imag = '0;
		cfg_we     = 1'b0;
		cfg_addr   = '0;
		cfg_wdata  = '0;
		set_idling(20, 82);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_point(0, 0);
		send_point(TWO_Q, 0);
		send_point(0, -TWO_Q);
		send_point(-TWO_Q, 0);
		send_point(0, TWO_Q);
		send_point(TWO_Q + 1, 0);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(32'sh8000_0000, 0);
		send_point(-1, -1);
		send_point(1, 1);
		send_point(ONE_Q / 3, -ONE_Q / 5);
		wait_idle();

		write_reg(REG_JULIA_REAL, COEF_W'(TWO_Q));
		write_reg(REG_JULIA_IMAG, COEF_W'(-TWO_Q));
		write_reg(REG_JULIA_REAL, COEF_W'(TWO_Q + 1));
		write_reg(REG_JULIA_IMAG, 31'h4000_0000);
		write_reg(REG_MAX_ITER, 31'd1023);
		write_reg(REG_POWER_MODE, 31'd1);
		send_point(0, 0);
		send_point(TWO_Q, -TWO_Q);
		send_point(32'sh7FFF_FFFF, 0);
		send_point(-ONE_Q, ONE_Q / 2);
		wait_idle();

		write_reg(REG_JULIA_REAL, 31'd0);
		write_reg(REG_JULIA_IMAG, 31'd0);
		send_point(0, 0);
		send_point(ONE_Q, 0);
		send_point(0, TWO_Q);
		wait_idle();

		write_reg(REG_MAX_ITER, 31'd0);
		write_reg(REG_POWER_MODE, 31'd0);
		send_point(0, 0);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_point(TWO_Q, 0);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 3) set_idling(20, 82);
			else if (ph < 6) set_idling(82, 20);
			else set_idling(0, 0);
			if ($urandom_range(3) == 0) write_reg(REG_JULIA_REAL, COEF_W'($urandom()));
			if ($urandom_range(3) == 0) write_reg(REG_JULIA_IMAG, COEF_W'($urandom()));
			write_reg(REG_JULIA_REAL, random_coef());
			write_reg(REG_JULIA_IMAG, random_coef());
			if (ph == 3) cap_val = $urandom_range(1023, 512);
			else if ($urandom_range(9) == 0) cap_val = 0;
			else cap_val = $urandom_range(64, 1);
			write_reg(REG_MAX_ITER, {21'($urandom()), CAP_W'(cap_val)});
			write_reg(REG_POWER_MODE, {30'($urandom()), 1'($urandom_range(1))});
			n_items = (ph == 3) ? 20 : 115;
			for (int i = 0; i < n_items; i++) send_point(random_coord(), random_coord());
			wait_idle();
		end

		if (sb.errors == 0 && sb.expected_counts.size() == 0) begin
			$display("[julia_escape_time_core] OK");
		end else begin
			$display("[julia_escape_time_core] ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/jet_pkg.sv
rtl/jet_front.sv
rtl/jet_queue.sv
rtl/jet_back.sv
rtl/julia_escape_time_core.sv
dv/tb_julia_escape_time_core.sv
